// ===== rtl/core/vdm_pkg.sv =====
package vdm_pkg;

  localparam int ELEM_BITS = 16;
  localparam int ACC_W     = 48;
  localparam int FRAC_W    = 24;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [1:0] METRIC_L2   = 2'd0;
  localparam logic [1:0] METRIC_DOT  = 2'd1;
  localparam logic [1:0] METRIC_COS  = 2'd2;
  localparam logic [1:0] METRIC_NONE = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] lhs_element;
    logic signed [ELEM_BITS-1:0] rhs_element;
    logic                        last_pair;
  } in_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] distance_value;
    logic [1:0]              status_code;
  } out_beat_t;

  // Finished sums of one vector pair, handed from the front to the back.
  typedef struct packed {
    logic signed [ACC_W-1:0] diff_sum;
    logic signed [ACC_W-1:0] cross_sum;
    logic signed [ACC_W-1:0] norm1_sum;
    logic signed [ACC_W-1:0] norm2_sum;
    logic                    sat;
    logic [1:0]              metric;
  } snap_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] sum;
  } sat_res_t;

  function automatic sat_res_t sat_add(input logic signed [ACC_W-1:0] acc,
                                       input logic signed [ACC_W-1:0] term);
    logic [ACC_W:0] s;
    sat_res_t       r;
    s = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    r.ovf = s[ACC_W] != s[ACC_W-1];
    if (!r.ovf) begin
      r.sum = s[ACC_W-1:0];
    end else if (s[ACC_W]) begin
      r.sum = ACC_MIN;
    end else begin
      r.sum = ACC_MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vdm_front.sv =====
module vdm_front #(
  parameter int MAX_DIM = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vdm_pkg::in_beat_t in_data,
  input  logic [1:0]       metric,
  input  logic             q_full,
  output logic             push,
  output vdm_pkg::snap_t   snap
);
  import vdm_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 2);

  // Product stage.
  logic                     p_valid_r;
  logic                     p_last_r;
  logic [2*ELEM_BITS:0]     p_dsq_r;
  logic signed [2*ELEM_BITS-1:0] p_cross_r;
  logic signed [2*ELEM_BITS-1:0] p_n1_r;
  logic signed [2*ELEM_BITS-1:0] p_n2_r;

  // Accumulator stage.
  logic signed [ACC_W-1:0] dsum_r, csum_r, n1sum_r, n2sum_r;
  logic                    sat_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                  advance;
  logic                  accept;
  logic signed [ELEM_BITS:0] diff;
  logic [ELEM_BITS:0]    adiff;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  too_long;
  sat_res_t              rd, rc, r1, r2;

  assign advance  = !(p_valid_r && p_last_r && q_full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign diff  = {in_data.lhs_element[ELEM_BITS-1], in_data.lhs_element}
               - {in_data.rhs_element[ELEM_BITS-1], in_data.rhs_element};
  assign adiff = diff[ELEM_BITS] ? (ELEM_BITS+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (advance) begin
      p_valid_r <= accept;
    end
    if (accept) begin
      p_last_r  <= in_data.last_pair;
      p_dsq_r   <= {{ELEM_BITS{1'b0}}, adiff} * {{ELEM_BITS{1'b0}}, adiff};
      p_cross_r <= in_data.lhs_element * in_data.rhs_element;
      p_n1_r    <= in_data.lhs_element * in_data.lhs_element;
      p_n2_r    <= in_data.rhs_element * in_data.rhs_element;
    end
  end

  always_comb begin
    rd = sat_add(dsum_r, ACC_W'({1'b0, p_dsq_r}));
    rc = sat_add(csum_r, ACC_W'(p_cross_r));
    r1 = sat_add(n1sum_r, ACC_W'(p_n1_r));
    r2 = sat_add(n2sum_r, ACC_W'(p_n2_r));
    cnt_nxt  = (cnt_r <= CNT_W'(MAX_DIM)) ? cnt_r + 1'b1 : cnt_r;
    too_long = cnt_nxt > CNT_W'(MAX_DIM);
  end

  assign push           = p_valid_r && p_last_r && advance;
  assign snap.diff_sum  = rd.sum;
  assign snap.cross_sum = rc.sum;
  assign snap.norm1_sum = r1.sum;
  assign snap.norm2_sum = r2.sum;
  assign snap.sat       = sat_r | too_long | rd.ovf | rc.ovf | r1.ovf | r2.ovf;
  assign snap.metric    = metric;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsum_r  <= '0;
      csum_r  <= '0;
      n1sum_r <= '0;
      n2sum_r <= '0;
      sat_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (p_valid_r && advance) begin
      if (p_last_r) begin
        dsum_r  <= '0;
        csum_r  <= '0;
        n1sum_r <= '0;
        n2sum_r <= '0;
        sat_r   <= 1'b0;
        cnt_r   <= '0;
      end else begin
        dsum_r  <= rd.sum;
        csum_r  <= rc.sum;
        n1sum_r <= r1.sum;
        n2sum_r <= r2.sum;
        sat_r   <= snap.sat;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/vdm_queue.sv =====
module vdm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vdm_pkg::snap_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output vdm_pkg::snap_t rd_data
);
  import vdm_pkg::*;

  localparam int DEPTH = 2;

  snap_t      entry_r [DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] count_r;

  assign full      = count_r == 2'(DEPTH);
  assign not_empty = count_r != 2'd0;
  assign rd_data   = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/vdm_back.sv =====
module vdm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  vdm_pkg::snap_t    q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output vdm_pkg::out_beat_t out_data
);
  import vdm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int HALF  = ACC_W / 2;
  localparam int NUM_W = ACC_W + FRAC_W;
  localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};

  logic [2:0]              state_r;
  snap_t                   e_r;
  logic signed [ACC_W-1:0] res_r;
  logic                    zero_r;
  logic                    dsat_r;
  logic [2*ACC_W-1:0]      prod_r;
  logic [6:0]              step_r;
  logic [ACC_W-1:0]        root_r;
  logic [ACC_W+1:0]        rem_r;
  logic [NUM_W-1:0]        num_r;
  logic [ACC_W-1:0]        drem_r;
  logic [FRAC_W+1:0]       quo_r;
  logic                    big_r;
  logic                    out_valid_r;
  out_beat_t               out_data_r;

  logic [HALF-1:0]    ma, mb;
  logic [2*HALF-1:0]  pp;
  logic [2*ACC_W-1:0] pp_sh;
  logic [ACC_W+3:0]   sq_t, sq_trial;
  logic [ACC_W:0]     dv_t;
  logic [ACC_W-1:0]   mag;
  logic [FRAC_W+2:0]  q_rnd;
  logic [FRAC_W:0]    q_lim;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = state_r == S_IDLE && q_valid;

  always_comb begin
    ma = step_r[1] ? e_r.norm1_sum[ACC_W-1:HALF] : e_r.norm1_sum[HALF-1:0];
    mb = step_r[0] ? e_r.norm2_sum[ACC_W-1:HALF] : e_r.norm2_sum[HALF-1:0];
    pp = ma * mb;
    case (step_r[1:0])
      2'd0:    pp_sh = (2*ACC_W)'(pp);
      2'd3:    pp_sh = (2*ACC_W)'(pp) << ACC_W;
      default: pp_sh = (2*ACC_W)'(pp) << HALF;
    endcase
    sq_t     = {rem_r, prod_r[2*ACC_W-1 -: 2]};
    sq_trial = {2'b00, root_r, 2'b01};
    dv_t     = {drem_r, num_r[NUM_W-1]};
    mag      = e_r.cross_sum[ACC_W-1] ? ACC_W'(-e_r.cross_sum) : e_r.cross_sum;
    q_rnd    = {1'b0, quo_r} + (FRAC_W+3)'(drem_r >= root_r - drem_r);
    q_lim    = (big_r || q_rnd > (FRAC_W+3)'(ONE)) ? ONE : q_rnd[FRAC_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            e_r     <= q_data;
            zero_r  <= 1'b0;
            dsat_r  <= 1'b0;
            res_r   <= '0;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (e_r.metric)
            METRIC_L2: begin
              res_r   <= e_r.diff_sum;
              state_r <= S_DONE;
            end
            METRIC_DOT: begin
              if (e_r.cross_sum == ACC_MIN) begin
                res_r  <= ACC_MAX;
                dsat_r <= 1'b1;
              end else begin
                res_r <= -e_r.cross_sum;
              end
              state_r <= S_DONE;
            end
            METRIC_COS: begin
              if (e_r.norm1_sum <= 0 || e_r.norm2_sum <= 0) begin
                zero_r  <= 1'b1;
                state_r <= S_DONE;
              end else begin
                prod_r  <= '0;
                step_r  <= '0;
                state_r <= S_MUL;
              end
            end
            default: begin
              res_r   <= '0;
              state_r <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          prod_r <= prod_r + pp_sh;
          if (step_r[1:0] == 2'd3) begin
            step_r  <= '0;
            root_r  <= '0;
            rem_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_SQRT: begin
          prod_r <= prod_r << 2;
          if (sq_t >= sq_trial) begin
            rem_r  <= (ACC_W+2)'(sq_t - sq_trial);
            root_r <= {root_r[ACC_W-2:0], 1'b1};
          end else begin
            rem_r  <= sq_t[ACC_W+1:0];
            root_r <= {root_r[ACC_W-2:0], 1'b0};
          end
          if (step_r == 7'(ACC_W - 1)) begin
            step_r  <= '0;
            num_r   <= {mag, {FRAC_W{1'b0}}};
            drem_r  <= '0;
            quo_r   <= '0;
            big_r   <= 1'b0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DIV: begin
          num_r <= num_r << 1;
          big_r <= big_r | quo_r[FRAC_W+1];
          if (dv_t >= {1'b0, root_r}) begin
            drem_r <= ACC_W'(dv_t - {1'b0, root_r});
            quo_r  <= {quo_r[FRAC_W:0], 1'b1};
          end else begin
            drem_r <= dv_t[ACC_W-1:0];
            quo_r  <= {quo_r[FRAC_W:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == 7'(NUM_W - 1)) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (e_r.cross_sum[ACC_W-1]) begin
            res_r <= ACC_W'(ONE) + ACC_W'(q_lim);
          end else begin
            res_r <= ACC_W'(ONE) - ACC_W'(q_lim);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r               <= 1'b1;
            out_data_r.distance_value <= res_r;
            if (e_r.sat || dsat_r) begin
              out_data_r.status_code <= STATUS_SAT;
            end else if (zero_r) begin
              out_data_r.status_code <= STATUS_ZERO;
            end else begin
              out_data_r.status_code <= STATUS_OK;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/vector_distance_metric_core.sv =====
// Vector distance engine: streams two vectors as element pairs and returns one
// metric per vector pair.
// Input channel (in_*): one beat per element pair, signed Q4.12 elements, with
// last_pair set on the final pair. A beat is taken when in_valid is high and
// in_stall is low; pairs are taken one per cycle while the result queue has room.
// Configuration (cfg_*): one register, the metric select (0 squared L2,
// 1 negated dot product, 2 cosine distance). cfg_ready is always high; write it
// only while the block is idle.
// Result channel (out_*): one beat per vector pair, a 48-bit value with 24
// fraction bits and a status code. It is taken when out_valid is high and
// out_stall is low; a stalled beat holds steady and the back end waits behind it.
// Path: squared L2 and dot results pass the product register, the result queue,
// and the back end's idle, evaluate and done states into the output register.
// Cosine adds a split multiply, a square root, a divide and a rounding step.
// Pacing: the back end works on one vector pair at a time and pops the queue only
// when idle. A two-entry queue sits between the accumulators and the back end, so
// the next vectors stream in while a result is computed; input stalls only when
// the queue is full and a last pair is waiting for it.
// Reset clears the sums, the queue, the output valid flag and selects squared L2.
module vector_distance_metric_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vdm_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vdm_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import vdm_pkg::*;

  // Metric select register.
  logic [1:0] metric_r;

  logic  push, q_full, pop, q_valid;
  snap_t snap_w, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_L2;
    end else if (cfg_valid && cfg_ready) begin
      metric_r <= cfg_data;
    end
  end

  // Front end: products then saturating accumulation, one pair per cycle while not stalled.
  vdm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .metric  (metric_r),
    .q_full  (q_full),
    .push    (push),
    .snap    (snap_w)
  );

  // Finished sums wait here for the back end.
  vdm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (snap_w),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .rd_data  (q_data)
  );

  // Back end: metric selection, cosine multiply, root, divide and rounding, output register.
  vdm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
